// ----- hw/rtl/mtu_pkg.sv -----
// Shared types, command codes and saturating fixed-point helpers for the matrix transform unit.
package mtu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DW            = 32;

	typedef enum logic [2:0] {
		CMD_IDENTITY = 3'd0,
		CMD_QUAT     = 3'd1,
		CMD_MULCOL   = 3'd2,
		CMD_XFORM    = 3'd3,
		CMD_INVERT   = 3'd4
	} cmd_t;

	typedef logic signed [DW-1:0] elem_t;

	typedef struct packed {
		elem_t val;
		logic  flag;
	} sres_t;

	function automatic sres_t sat32(input logic signed [63:0] v);
		sres_t r;
		r.flag = 1'b0;
		r.val  = v[DW-1:0];
		if (v > 64'sd2147483647) begin
			r.val  = 32'sh7fffffff;
			r.flag = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.val  = 32'sh80000000;
			r.flag = 1'b1;
		end
		return r;
	endfunction

	// exact product, arithmetic shift floors, then clamp
	function automatic sres_t fmul(input elem_t a, input elem_t b, input int fb);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat32(p >>> fb);
	endfunction

	function automatic sres_t fadd(input elem_t a, input elem_t b);
		return sat32(64'(a) + 64'(b));
	endfunction

	function automatic sres_t fsub(input elem_t a, input elem_t b);
		return sat32(64'(a) - 64'(b));
	endfunction

endpackage

// ----- hw/rtl/mtu_lane.sv -----
// One dot-product lane: a matrix row times a four-element operand, saturating.
module mtu_lane #(
	parameter int FRAC_BITS = mtu_pkg::FRAC_BITS_DEF
) (
	input  mtu_pkg::elem_t row [4],
	input  mtu_pkg::elem_t b   [4],
	output mtu_pkg::elem_t sum,
	output logic           sat
);
	import mtu_pkg::*;

	sres_t prod [4];
	sres_t tot;
	logic signed [63:0] acc;

	always_comb begin
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			prod[k] = fmul(row[k], b[k], FRAC_BITS);
			acc     = acc + 64'(prod[k].val);
		end
		tot = sat32(acc);
		sum = tot.val;
		sat = tot.flag | prod[0].flag | prod[1].flag | prod[2].flag | prod[3].flag;
	end

endmodule

// ----- hw/rtl/mtu_quat.sv -----
// Rotation matrix from a unit quaternion, column-major.
module mtu_quat #(
	parameter int FRAC_BITS = mtu_pkg::FRAC_BITS_DEF
) (
	input  mtu_pkg::elem_t w,
	input  mtu_pkg::elem_t x,
	input  mtu_pkg::elem_t y,
	input  mtu_pkg::elem_t z,
	output mtu_pkg::elem_t m [16]
);
	import mtu_pkg::*;

	localparam elem_t ONE = elem_t'(64'sd1 <<< FRAC_BITS);

	elem_t x2, y2, z2;
	elem_t xx, xy, xz, yy, yz, zz, wx, wy, wz;

	always_comb begin
		x2 = fadd(x, x).val;
		y2 = fadd(y, y).val;
		z2 = fadd(z, z).val;
		xx = fmul(x, x2, FRAC_BITS).val;
		xy = fmul(x, y2, FRAC_BITS).val;
		xz = fmul(x, z2, FRAC_BITS).val;
		yy = fmul(y, y2, FRAC_BITS).val;
		yz = fmul(y, z2, FRAC_BITS).val;
		zz = fmul(z, z2, FRAC_BITS).val;
		wx = fmul(w, x2, FRAC_BITS).val;
		wy = fmul(w, y2, FRAC_BITS).val;
		wz = fmul(w, z2, FRAC_BITS).val;
		m[0]  = fsub(ONE, fadd(yy, zz).val).val;
		m[1]  = fadd(xy, wz).val;
		m[2]  = fsub(xz, wy).val;
		m[3]  = '0;
		m[4]  = fsub(xy, wz).val;
		m[5]  = fsub(ONE, fadd(xx, zz).val).val;
		m[6]  = fadd(yz, wx).val;
		m[7]  = '0;
		m[8]  = fadd(xz, wy).val;
		m[9]  = fsub(yz, wx).val;
		m[10] = fsub(ONE, fadd(xx, yy).val).val;
		m[11] = '0;
		m[12] = '0;
		m[13] = '0;
		m[14] = '0;
		m[15] = ONE;
	end

endmodule

// ----- hw/rtl/matrix_transform_unit_core.sv -----
// Top level of the matrix transform unit: matrix store, four lanes, merge and output register.
// Usage:
//  Input channel in_valid/in_ready carries one command word: command, column, a0..a3.
//  Output channel out_valid/out_ready carries r0..r3 and saturated.
//  Identity, quaternion load and invert update the matrix and give no output word.
//  Multiply column returns the product column and stores it in the shadow store;
//  column 3 commits the shadow store (with the new column) as the current matrix.
//  Transform vector returns the 3x3 product of a0..a2 with r3 = 0.
//  A result word is registered and appears in the cycle after its command is accepted.
//  Throughput: one command per cycle while in_ready is high; four multiply lanes
//  form a matrix column combinationally, and the matrix update lands at the same
//  edge as the result word, so the next command sees it at once.
//  Reset loads the identity matrix and empties the output register; the shadow
//  store is not cleared.
//  When the receiver stalls, the held word stays on the outputs and in_ready
//  falls only while a word is held and not being taken.
//  The saturated bit flags any clamped product or sum of that command.
module matrix_transform_unit_core #(
	parameter int FRAC_BITS = mtu_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     command,
	input  logic [1:0]     column,
	input  mtu_pkg::elem_t a0,
	input  mtu_pkg::elem_t a1,
	input  mtu_pkg::elem_t a2,
	input  mtu_pkg::elem_t a3,
	output logic           out_valid,
	input  logic           out_ready,
	output mtu_pkg::elem_t r0,
	output mtu_pkg::elem_t r1,
	output mtu_pkg::elem_t r2,
	output mtu_pkg::elem_t r3,
	output logic           saturated
);
	import mtu_pkg::*;

	localparam elem_t ONE = elem_t'(64'sd1 <<< FRAC_BITS);

	elem_t mat_q  [16];
	elem_t pend_q [16];
	elem_t quat_m [16];
	elem_t opnd   [4];
	elem_t rows   [4][4];
	elem_t lsum   [4];
	logic  lsat   [4];
	cmd_t  cmd;
	logic  accept;
	logic  has_res;
	logic  res_sat;
	logic  out_valid_q;
	elem_t r_q [4];
	logic  sat_q;

	assign cmd      = cmd_t'(command);
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign has_res  = (cmd == CMD_MULCOL) || (cmd == CMD_XFORM);

	always_comb begin
		opnd[0] = a0;
		opnd[1] = a1;
		opnd[2] = a2;
		opnd[3] = (cmd == CMD_XFORM) ? '0 : a3;
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 4; k++)
				rows[i][k] = mat_q[k*4 + i];
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		mtu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.row (rows[g]),
			.b   (opnd),
			.sum (lsum[g]),
			.sat (lsat[g])
		);
	end

	mtu_quat #(.FRAC_BITS(FRAC_BITS)) u_quat (
		.w (a0),
		.x (a1),
		.y (a2),
		.z (a3),
		.m (quat_m)
	);

	// merge: row 3 lane does not count for a vector transform
	assign res_sat = lsat[0] | lsat[1] | lsat[2] | ((cmd == CMD_MULCOL) & lsat[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				mat_q[i] <= (i % 5 == 0) ? ONE : '0;
		end else if (accept) begin
			case (cmd)
				CMD_IDENTITY: begin
					for (int i = 0; i < 16; i++)
						mat_q[i] <= (i % 5 == 0) ? ONE : '0;
				end
				CMD_QUAT: begin
					mat_q <= quat_m;
				end
				CMD_MULCOL: begin
					if (column == 2'd3) begin
						for (int i = 0; i < 12; i++)
							mat_q[i] <= pend_q[i];
						for (int i = 0; i < 4; i++)
							mat_q[12 + i] <= lsum[i];
					end
				end
				CMD_INVERT: begin
					mat_q[1] <= mat_q[4];
					mat_q[4] <= mat_q[1];
					mat_q[2] <= mat_q[8];
					mat_q[8] <= mat_q[2];
					mat_q[6] <= mat_q[9];
					mat_q[9] <= mat_q[6];
					for (int i = 12; i < 15; i++)
						mat_q[i] <= fsub('0, mat_q[i]).val;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_MULCOL) begin
			for (int i = 0; i < 4; i++)
				pend_q[{column, 2'(i)}] <= lsum[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= has_res;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept && has_res) begin
			r_q[0] <= lsum[0];
			r_q[1] <= lsum[1];
			r_q[2] <= lsum[2];
			r_q[3] <= (cmd == CMD_XFORM) ? '0 : lsum[3];
			sat_q  <= res_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign r0        = r_q[0];
	assign r1        = r_q[1];
	assign r2        = r_q[2];
	assign r3        = r_q[3];
	assign saturated = sat_q;

endmodule

// ----- hw/rtl/mtu_checker.sv -----
// Port-level checks for the matrix transform unit, bound to the top level.
module mtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] r0,
	input logic [31:0] r3
);
	import mtu_pkg::*;

	logic acc_res;
	assign acc_res = in_valid && in_ready &&
		(command == CMD_MULCOL || command == CMD_XFORM);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r0))
		else $error("output word dropped or changed while stalled");

	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		acc_res |=> out_valid)
		else $error("result word missing after command");

	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !acc_res |=> !out_valid)
		else $error("word produced by a command with no result");

	a_xform_r3: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_XFORM |=> r3 == '0)
		else $error("vector transform gave non-zero r3");

endmodule

bind matrix_transform_unit_core mtu_checker u_mtu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.r0        (r0),
	.r3        (r3)
);
